// File: design/psdtm_pkg.sv
// Shared types, register indexes and parameter defaults for the mono dither pixel mapper.
`timescale 1ns / 1ps

package psdtm_pkg;

    localparam int DEF_SOURCE_WIDTH    = 128;
    localparam int DEF_SCALED_WIDTH    = 240;
    localparam int DEF_DISPLAY_COLUMNS = 400;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SET_IS_WHITE = 2'd2;

    typedef enum logic [1:0] {
        FMT_ONE_BIT = 2'd0,
        FMT_RGB332  = 2'd1,
        FMT_RGB565  = 2'd2
    } t_pix_fmt;

    typedef struct packed {
        logic       scale_enable;
        logic [1:0] pixel_format;
        logic       set_is_white;
    } t_cfg;

    typedef struct packed {
        logic [8:0] display_column;
        logic [1:0] pixel_count;
        logic       first_white;
        logic       second_white;
    } t_result;

endpackage

// File: design/pixel_scale_dither_to_mono_core.sv
// Top level of the mono dither pixel mapper: handshake stages and configuration registers.
// A word accepted at the input is held in the input register and then in the result register, where it is valid.
// Throughput: one word per cycle while the output is not stalled; the input register and the result register form an
// elastic two-stage pipeline, so one more word is taken while a result waits.
// Reset clears both stage valids and sets scale_enable 0, pixel_format RGB565 and
// set_is_white 1.
`timescale 1ns / 1ps

module pixel_scale_dither_to_mono_core #(
    parameter int SOURCE_WIDTH    = psdtm_pkg::DEF_SOURCE_WIDTH,
    parameter int SCALED_WIDTH    = psdtm_pkg::DEF_SCALED_WIDTH,
    parameter int DISPLAY_COLUMNS = psdtm_pkg::DEF_DISPLAY_COLUMNS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [psdtm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [psdtm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [15:0]                      i_pixel_value,
    input  logic [6:0]                       i_source_column,
    input  logic [7:0]                       i_display_row,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [8:0]                       o_display_column,
    output logic [1:0]                       o_pixel_count,
    output logic                             o_first_white,
    output logic                             o_second_white
);

    psdtm_pkg::t_cfg    r_cfg;
    logic               r_in_valid;
    logic [15:0]        r_pix;
    logic [6:0]         r_col;
    logic [1:0]         r_row_phase;
    logic               r_out_valid;
    psdtm_pkg::t_result r_res;
    psdtm_pkg::t_result w_res;
    logic               w_out_free;
    logic               w_in_ready;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_in_ready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_enable <= 1'b0;
            r_cfg.pixel_format <= psdtm_pkg::FMT_RGB565;
            r_cfg.set_is_white <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                psdtm_pkg::CFG_SCALE_ENABLE: begin
                    r_cfg.scale_enable <= i_cfg_data[0];
                end
                psdtm_pkg::CFG_PIXEL_FORMAT: begin
                    r_cfg.pixel_format <= i_cfg_data[1:0];
                end
                psdtm_pkg::CFG_SET_IS_WHITE: begin
                    r_cfg.set_is_white <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_in_ready) begin
            r_pix       <= i_pixel_value;
            r_col       <= i_source_column;
            r_row_phase <= i_display_row[1:0];
        end
        if (r_in_valid && w_out_free) begin
            r_res <= w_res;
        end
    end

    psdtm_map #(
        .SOURCE_WIDTH    (SOURCE_WIDTH),
        .SCALED_WIDTH    (SCALED_WIDTH),
        .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
    ) u_map (
        .i_cfg           (r_cfg),
        .i_pixel_value   (r_pix),
        .i_source_column (r_col),
        .i_row_phase     (r_row_phase),
        .o_res           (w_res)
    );

    assign o_in_ready       = w_in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_display_column = r_res.display_column;
    assign o_pixel_count    = r_res.pixel_count;
    assign o_first_white    = r_res.first_white;
    assign o_second_white   = r_res.second_white;

    a_centred_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !r_cfg.scale_enable) |-> (o_pixel_count == 2'd1))
        else $error("centred mapping gave a count other than one");

    a_second_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_pixel_count != 2'd2)) |-> !o_second_white)
        else $error("second pixel white although not covered");

    a_empty_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_pixel_count == 2'd0)) |-> !o_first_white)
        else $error("first pixel white on an empty span");

    a_mono_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_cfg.pixel_format == psdtm_pkg::FMT_ONE_BIT)
         && (o_pixel_count == 2'd2)) |-> (o_first_white == o_second_white))
        else $error("one-bit pixel gave two different display pixels");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while both stages are full and stalled");

endmodule

// File: design/psdtm_map.sv
// Column mapping, brightness weighting and ordered-dither decision for one source pixel.
`timescale 1ns / 1ps

module psdtm_map #(
    parameter int SOURCE_WIDTH    = psdtm_pkg::DEF_SOURCE_WIDTH,
    parameter int SCALED_WIDTH    = psdtm_pkg::DEF_SCALED_WIDTH,
    parameter int DISPLAY_COLUMNS = psdtm_pkg::DEF_DISPLAY_COLUMNS
) (
    input  psdtm_pkg::t_cfg    i_cfg,
    input  logic [15:0]        i_pixel_value,
    input  logic [6:0]         i_source_column,
    input  logic [1:0]         i_row_phase,
    output psdtm_pkg::t_result o_res
);

    localparam int CENTRE_OFFS = (DISPLAY_COLUMNS - SOURCE_WIDTH) / 2;
    localparam int SCALE_OFFS  = (DISPLAY_COLUMNS - SCALED_WIDTH) / 2;
    localparam int COLUMNS     = 128;

    localparam logic [7:0] BAYER [4][4] = '{
        '{8'd8,   8'd136, 8'd40,  8'd168},
        '{8'd200, 8'd72,  8'd232, 8'd104},
        '{8'd56,  8'd184, 8'd24,  8'd152},
        '{8'd248, 8'd120, 8'd216, 8'd88}
    };

    logic [8:0]  w_col_tab [COLUMNS];
    logic [1:0]  w_cnt_tab [COLUMNS];

    // The scaled edge table is worked out at elaboration, one entry per source column.
    for (genvar gx = 0; gx < COLUMNS; gx++) begin : g_edge
        localparam int LO   = (gx * SCALED_WIDTH + SOURCE_WIDTH - 1) / SOURCE_WIDTH;
        localparam int HI   = ((gx + 1) * SCALED_WIDTH + SOURCE_WIDTH - 1) / SOURCE_WIDTH;
        localparam int EDGE = SCALE_OFFS + LO;
        localparam int SPAN = HI - LO;
        assign w_col_tab[gx] = 9'(EDGE);
        assign w_cnt_tab[gx] = (SPAN > 2) ? 2'd2 : 2'(SPAN);
    end

    logic [8:0]  w_col;
    logic [1:0]  w_cnt;
    logic [15:0] w_rgb;
    logic [7:0]  w_r8;
    logic [7:0]  w_g8;
    logic [7:0]  w_b8;
    logic [15:0] w_lum_sum;
    logic [7:0]  w_lum;
    logic [1:0]  w_phase1;
    logic        w_mono;
    logic        w_w0;
    logic        w_w1;

    always_comb begin
        if (i_cfg.scale_enable) begin
            w_col = w_col_tab[i_source_column];
            w_cnt = w_cnt_tab[i_source_column];
        end else begin
            w_col = 9'(CENTRE_OFFS) + {2'b00, i_source_column};
            w_cnt = 2'd1;
        end
    end

    always_comb begin
        case (i_cfg.pixel_format)
            psdtm_pkg::FMT_RGB332: begin
                w_rgb = {5'((6'({3'b000, i_pixel_value[7:5]}) * 6'd9) >> 1),
                         6'({3'b000, i_pixel_value[4:2]}) * 6'd9,
                         5'((8'({6'b000000, i_pixel_value[1:0]}) * 8'h55) >> 3)};
            end
            default: begin
                w_rgb = i_pixel_value;
            end
        endcase
    end

    assign w_r8      = {w_rgb[15:11], 3'b000};
    assign w_g8      = {w_rgb[10:5], 2'b00};
    assign w_b8      = {w_rgb[4:0], 3'b000};
    assign w_lum_sum = {8'd0, w_r8} * 16'd77 + {8'd0, w_g8} * 16'd150
                     + {8'd0, w_b8} * 16'd29;
    assign w_lum     = w_lum_sum[15:8];
    assign w_phase1  = w_col[1:0] + 2'd1;
    assign w_mono    = (i_pixel_value[0] == i_cfg.set_is_white);

    always_comb begin
        if (i_cfg.pixel_format == psdtm_pkg::FMT_ONE_BIT) begin
            w_w0 = w_mono;
            w_w1 = w_mono;
        end else begin
            w_w0 = (w_lum > BAYER[i_row_phase][w_col[1:0]]);
            w_w1 = (w_lum > BAYER[i_row_phase][w_phase1]);
        end
    end

    assign o_res.display_column = w_col;
    assign o_res.pixel_count    = w_cnt;
    assign o_res.first_white    = w_w0 && (w_cnt != 2'd0);
    assign o_res.second_white   = w_w1 && (w_cnt == 2'd2);

endmodule

// File: tb/tb_pixel_scale_dither_to_mono_core.sv
// Self-checking testbench for the mono dither pixel mapper with handshake stalls and mode sweeps.
`timescale 1ns / 1ps

module tb_pixel_scale_dither_to_mono_core;

    localparam int SRC_W   = psdtm_pkg::DEF_SOURCE_WIDTH;
    localparam int SCL_W   = psdtm_pkg::DEF_SCALED_WIDTH;
    localparam int DISP_W  = psdtm_pkg::DEF_DISPLAY_COLUMNS;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_PHASES = 16;
    localparam int WORDS_PER_PHASE = 54;
    localparam int HOLD_OFF_LENGTH = 300;

    localparam logic [psdtm_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam logic [1:0]                        FMT_UNUSED       = 2'd3;

    localparam logic [0:15][7:0] BAYER_4X4 = {
        8'd8,   8'd136, 8'd40,  8'd168,
        8'd200, 8'd72,  8'd232, 8'd104,
        8'd56,  8'd184, 8'd24,  8'd152,
        8'd248, 8'd120, 8'd216, 8'd88
    };

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [psdtm_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [psdtm_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                              i_in_valid;
    logic                              o_in_ready;
    logic [15:0]                       i_pixel_value;
    logic [6:0]                        i_source_column;
    logic [7:0]                        i_display_row;
    logic                              o_out_valid;
    logic                              i_out_ready;
    logic [8:0]                        o_display_column;
    logic [1:0]                        o_pixel_count;
    logic                              o_first_white;
    logic                              o_second_white;

    logic       mode_scale;
    logic [1:0] mode_format;
    logic       mode_set_white;

    psdtm_pkg::t_result pending_results[$];
    int                 mismatch_count;
    int                 words_sent;
    int                 words_checked;
    int                 hold_off_cycles;
    bit                 in_gaps_on;
    bit                 out_gaps_on;

    pixel_scale_dither_to_mono_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pixel_value    (i_pixel_value),
        .i_source_column  (i_source_column),
        .i_display_row    (i_display_row),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_display_column (o_display_column),
        .o_pixel_count    (o_pixel_count),
        .o_first_white    (o_first_white),
        .o_second_white   (o_second_white)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned scaled_column_edge(int unsigned x);
        return (DISP_W - SCL_W) / 2 + (x * SCL_W + SRC_W - 1) / SRC_W;
    endfunction

    function automatic psdtm_pkg::t_result predict_mono_pixel(logic [15:0] pix,
                                                              logic [6:0] col,
                                                              logic [7:0] row);
        psdtm_pkg::t_result res;
        int unsigned        first_edge;
        int unsigned        next_edge;
        int unsigned        span;
        int unsigned        lum;
        int unsigned        rgb;
        int unsigned        thr_row;
        logic               level;
        logic               w0;
        logic               w1;
        if (mode_scale) begin
            first_edge = scaled_column_edge(col);
            next_edge  = scaled_column_edge(col + 1);
            span       = (next_edge > first_edge) ? next_edge - first_edge : 0;
            if (span > 2) begin
                span = 2;
            end
        end else begin
            first_edge = (DISP_W - SRC_W) / 2 + col;
            span       = 1;
        end
        if (mode_format == psdtm_pkg::FMT_ONE_BIT) begin
            level = (pix[0] == mode_set_white);
            w0    = level;
            w1    = level;
        end else begin
            if (mode_format == psdtm_pkg::FMT_RGB332) begin
                rgb = (((pix[7:5] * 9) >> 1) << 11) | ((pix[4:2] * 9) << 5)
                    | ((pix[1:0] * 85) >> 3);
            end else begin
                rgb = pix;
            end
            lum = ((((rgb >> 11) & 'h1F) << 3) * 77 + (((rgb >> 5) & 'h3F) << 2) * 150
                  + ((rgb & 'h1F) << 3) * 29) >> 8;
            lum = lum & 'hFF;
            thr_row = row[1:0];
            w0 = lum > BAYER_4X4[thr_row * 4 + (first_edge & 3)];
            w1 = lum > BAYER_4X4[thr_row * 4 + ((first_edge + 1) & 3)];
        end
        if (span < 1) begin
            w0 = 1'b0;
        end
        if (span < 2) begin
            w1 = 1'b0;
        end
        res.display_column = first_edge[8:0];
        res.pixel_count    = span[1:0];
        res.first_white    = w0;
        res.second_white   = w1;
        return res;
    endfunction

    task automatic send_pixel(input logic [15:0] pix, input logic [6:0] col,
                              input logic [7:0] row);
        int gap;
        gap = in_gaps_on ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_pixel_value   <= pix;
        i_source_column <= col;
        i_display_row   <= row;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_mono_pixel(pix, col, row));
        words_sent++;
    endtask

    task automatic send_random_pixel();
        send_pixel(16'($urandom), 7'($urandom_range(0, 127)), 8'($urandom_range(0, 239)));
    endtask

    task automatic drain_pipeline();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [psdtm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [1:0] data);
        drain_pipeline();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            psdtm_pkg::CFG_SCALE_ENABLE: mode_scale     = data[0];
            psdtm_pkg::CFG_PIXEL_FORMAT: mode_format    = data;
            psdtm_pkg::CFG_SET_IS_WHITE: mode_set_white = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_mode(input logic scale, input logic [1:0] fmt, input logic set_white);
        write_reg(psdtm_pkg::CFG_SCALE_ENABLE, {1'b0, scale});
        write_reg(psdtm_pkg::CFG_PIXEL_FORMAT, fmt);
        write_reg(psdtm_pkg::CFG_SET_IS_WHITE, {1'b0, set_white});
    endtask

    task automatic test_default_colour();
        send_pixel(16'h0000, 7'd0, 8'd0);
        send_pixel(16'hFFFF, 7'd127, 8'd239);
        send_pixel(16'hF800, 7'd5, 8'd1);
        send_pixel(16'h07E0, 7'd6, 8'd2);
        send_pixel(16'h001F, 7'd7, 8'd3);
        send_pixel(16'h8410, 7'd64, 8'd128);
    endtask

    task automatic test_one_bit_polarity();
        set_mode(1'b0, psdtm_pkg::FMT_ONE_BIT, 1'b1);
        send_pixel(16'h0001, 7'd0, 8'd0);
        send_pixel(16'hFFFE, 7'd127, 8'd3);
        set_mode(1'b0, psdtm_pkg::FMT_ONE_BIT, 1'b0);
        send_pixel(16'h0001, 7'd9, 8'd1);
        send_pixel(16'h0000, 7'd10, 8'd2);
    endtask

    task automatic test_rgb332_expansion();
        set_mode(1'b0, psdtm_pkg::FMT_RGB332, 1'b1);
        send_pixel(16'h00FF, 7'd0, 8'd0);
        send_pixel(16'hFF00, 7'd1, 8'd1);
        send_pixel(16'h00E0, 7'd2, 8'd2);
        send_pixel(16'h001C, 7'd3, 8'd3);
        send_pixel(16'h0003, 7'd4, 8'd0);
    endtask

    task automatic test_scaled_columns();
        set_mode(1'b1, psdtm_pkg::FMT_RGB565, 1'b1);
        send_pixel(16'hFFFF, 7'd0, 8'd0);
        send_pixel(16'h8410, 7'd1, 8'd1);
        send_pixel(16'hFFFF, 7'd2, 8'd2);
        send_pixel(16'h8410, 7'd126, 8'd3);
        send_pixel(16'hFFFF, 7'd127, 8'd239);
    endtask

    task automatic test_register_corners();
        set_mode(1'b1, psdtm_pkg::FMT_RGB565, 1'b1);
        // Only bit 0 of the data reaches the scale register, so this turns scaling off.
        write_reg(psdtm_pkg::CFG_SCALE_ENABLE, 2'd2);
        write_reg(psdtm_pkg::CFG_PIXEL_FORMAT, FMT_UNUSED);
        write_reg(CFG_UNUSED_INDEX, 2'd1);
        send_pixel(16'hFFFF, 7'd127, 8'd3);
        send_pixel(16'h4208, 7'd64, 8'd2);
        write_reg(psdtm_pkg::CFG_PIXEL_FORMAT, psdtm_pkg::FMT_ONE_BIT);
        write_reg(psdtm_pkg::CFG_SET_IS_WHITE, 2'd2);
        send_pixel(16'h0000, 7'd1, 8'd0);
        send_pixel(16'h0001, 7'd2, 8'd1);
    endtask

    task automatic test_random_modes();
        int phase;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_mode(phase[0], phase[2:1], phase[3]);
            in_gaps_on  = (phase % 4 == 0) || (phase % 4 == 2);
            out_gaps_on = (phase % 4 == 0) || (phase % 4 == 1);
            repeat (WORDS_PER_PHASE) send_random_pixel();
        end
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        set_mode(1'b1, psdtm_pkg::FMT_RGB332, 1'b0);
        in_gaps_on      = 1'b0;
        hold_off_cycles = HOLD_OFF_LENGTH;
        repeat (40) send_random_pixel();
        in_gaps_on = 1'b1;
    endtask

    initial begin : out_ready_driver
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off_cycles > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (hold_off_cycles - 1) @(negedge i_clk);
                hold_off_cycles = 0;
            end
            stall = out_gaps_on ? $urandom_range(0, 8) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : result_checker
        psdtm_pkg::t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("Result word arrived with none expected: column %0d count %0d",
                           o_display_column, o_pixel_count);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    words_checked++;
                    if (o_display_column !== want.display_column) begin
                        $error("display_column: expected %0d, actual %0d",
                               want.display_column, o_display_column);
                        mismatch_count++;
                    end
                    if (o_pixel_count !== want.pixel_count) begin
                        $error("pixel_count: expected %0d, actual %0d",
                               want.pixel_count, o_pixel_count);
                        mismatch_count++;
                    end
                    if (o_first_white !== want.first_white) begin
                        $error("first_white: expected %0b, actual %0b",
                               want.first_white, o_first_white);
                        mismatch_count++;
                    end
                    if (o_second_white !== want.second_white) begin
                        $error("second_white: expected %0b, actual %0b",
                               want.second_white, o_second_white);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

    initial begin : test_sequence
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = psdtm_pkg::CFG_SCALE_ENABLE;
        i_cfg_data      = 2'd0;
        i_in_valid      = 1'b0;
        i_pixel_value   = 16'h0000;
        i_source_column = 7'd0;
        i_display_row   = 8'd0;
        mode_scale      = 1'b0;
        mode_format     = psdtm_pkg::FMT_RGB565;
        mode_set_white  = 1'b1;
        mismatch_count  = 0;
        words_sent      = 0;
        words_checked   = 0;
        hold_off_cycles = 0;
        in_gaps_on      = 1'b1;
        out_gaps_on     = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_colour();
        test_one_bit_polarity();
        test_rgb332_expansion();
        test_scaled_columns();
        test_register_corners();
        test_random_modes();
        test_output_backpressure();
        drain_pipeline();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d pixel words and checked %0d result words.", words_sent,
                 words_checked);
        $display("Covered every format code, both scaling modes, both polarities %s",
                 "and a long output stall.");
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
